// File: design/planar_surface_address_walker_macros.svh
// Assertion macros shared by the surface address walker RTL.
// Expects clk and rst in scope at the point of use.
`ifndef PLANAR_SURFACE_ADDRESS_WALKER_MACROS_SVH
`define PLANAR_SURFACE_ADDRESS_WALKER_MACROS_SVH

// check a consequence in the same cycle
`define PSAW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check a consequence in the next cycle
`define PSAW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/psaw_pkg.sv
// Surface address walker package: widths, codes and the configuration struct.
// No dependencies; imported by every other file of the walker but the macros header.
`timescale 1ns / 1ps
`default_nettype none

package psaw_pkg;

  localparam int ADDR_BITS_DEFAULT = 32;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int ORIGIN_W    = 32;
  localparam int PITCH_W     = 16;
  localparam int FOFS_W      = 24;
  localparam int BPP_W       = 6;
  localparam int LAYOUT_W    = 3;

  localparam int REQ_W   = 3;
  localparam int POS_W   = 13;
  localparam int LINE_W  = 16;
  localparam int FIELD_W = 2;

  localparam int PROD_W  = POS_W + PITCH_W;
  localparam int XB_W    = POS_W + BPP_W + 1;
  localparam int XBYTE_W = XB_W - 3;

  localparam logic [BPP_W-1:0] BPP_RESET = BPP_W'(8);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LUMA_ORIGIN     = 3'd0,
    REG_CHROMA_A_ORIGIN = 3'd1,
    REG_CHROMA_B_ORIGIN = 3'd2,
    REG_LINE_PITCH      = 3'd3,
    REG_FIELD_OFFSET    = 3'd4,
    REG_BITS_PER_PIXEL  = 3'd5,
    REG_PLANE_LAYOUT    = 3'd6,
    REG_FIELDS_SEP      = 3'd7
  } cfg_reg_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET_POS   = 3'd0,
    REQ_NEXT_LINE = 3'd1,
    REQ_PREV_LINE = 3'd2,
    REQ_CRAB      = 3'd3,
    REQ_RCRAB     = 3'd4
  } req_t;

  typedef enum logic [LAYOUT_W-1:0] {
    LAYOUT_PACKED = 3'd0,
    LAYOUT_3P420  = 3'd1,
    LAYOUT_3P422  = 3'd2,
    LAYOUT_2P420  = 3'd3,
    LAYOUT_2P422  = 3'd4,
    LAYOUT_3P444  = 3'd5
  } layout_t;

  typedef struct packed {
    logic [ORIGIN_W-1:0] luma_origin;
    logic [ORIGIN_W-1:0] chroma_a_origin;
    logic [ORIGIN_W-1:0] chroma_b_origin;
    logic [PITCH_W-1:0]  line_pitch;
    logic [FOFS_W-1:0]   second_field_offset;
    logic [BPP_W-1:0]    bits_per_pixel;
    layout_t             plane_layout;
    logic                fields_separated;
  } cfg_t;

endpackage

`default_nettype wire

// File: design/psaw_req_if.sv
// Request channel of the walker: valid/ready handshake with request payload.
// Depends on psaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface psaw_req_if;
  import psaw_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;

  modport source (output valid, output req_type, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input req_type, input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

// File: design/psaw_res_if.sv
// Result channel of the walker: valid/ready handshake with plane addresses and counters.
// Depends on psaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface psaw_res_if #(
  parameter int ADDR_BITS = psaw_pkg::ADDR_BITS_DEFAULT
);
  import psaw_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ADDR_BITS-1:0]      luma_addr;
  logic [ADDR_BITS-1:0]      chroma_a_addr;
  logic [ADDR_BITS-1:0]      chroma_b_addr;
  logic signed [LINE_W-1:0]  cur_line;
  logic [FIELD_W-1:0]        field_count;

  modport source (output valid, output luma_addr, output chroma_a_addr,
                  output chroma_b_addr, output cur_line, output field_count,
                  input ready);
  modport sink   (input valid, input luma_addr, input chroma_a_addr,
                  input chroma_b_addr, input cur_line, input field_count,
                  output ready);
endinterface

`default_nettype wire

// File: design/psaw_cfg_regs.sv
// Configuration register file of the walker, written through a plain write port.
// Depends on psaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psaw_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [psaw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [psaw_pkg::CFG_DATA_W-1:0]  cfg_data,
  output psaw_pkg::cfg_t                   cfg
);
  import psaw_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.luma_origin         <= '0;
      cfg.chroma_a_origin     <= '0;
      cfg.chroma_b_origin     <= '0;
      cfg.line_pitch          <= '0;
      cfg.second_field_offset <= '0;
      cfg.bits_per_pixel      <= BPP_RESET;
      cfg.plane_layout        <= LAYOUT_PACKED;
      cfg.fields_separated    <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LUMA_ORIGIN:     cfg.luma_origin         <= cfg_data[ORIGIN_W-1:0];
        REG_CHROMA_A_ORIGIN: cfg.chroma_a_origin     <= cfg_data[ORIGIN_W-1:0];
        REG_CHROMA_B_ORIGIN: cfg.chroma_b_origin     <= cfg_data[ORIGIN_W-1:0];
        REG_LINE_PITCH:      cfg.line_pitch          <= cfg_data[PITCH_W-1:0];
        REG_FIELD_OFFSET:    cfg.second_field_offset <= cfg_data[FOFS_W-1:0];
        REG_BITS_PER_PIXEL:  cfg.bits_per_pixel      <= cfg_data[BPP_W-1:0];
        REG_PLANE_LAYOUT:    cfg.plane_layout        <= layout_t'(cfg_data[LAYOUT_W-1:0]);
        REG_FIELDS_SEP:      cfg.fields_separated    <= cfg_data[0];
        default:             cfg.fields_separated    <= cfg.fields_separated;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/psaw_next_state.sv
// Next-state logic of the walker: set position, line steps and crab steps.
// Depends on psaw_pkg; purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module psaw_next_state #(
  parameter int ADDR_BITS = psaw_pkg::ADDR_BITS_DEFAULT
) (
  input  psaw_pkg::cfg_t                 cfg,
  input  logic [psaw_pkg::REQ_W-1:0]     req_type,
  input  logic [psaw_pkg::POS_W-1:0]     pos_x,
  input  logic [psaw_pkg::POS_W-1:0]     pos_y,
  input  logic [ADDR_BITS-1:0]           luma_ptr,
  input  logic [ADDR_BITS-1:0]           chroma_a_ptr,
  input  logic [ADDR_BITS-1:0]           chroma_b_ptr,
  input  logic [psaw_pkg::LINE_W-1:0]    line_count,
  input  logic [psaw_pkg::FIELD_W-1:0]   field_ctr,
  output logic [ADDR_BITS-1:0]           luma_ptr_next,
  output logic [ADDR_BITS-1:0]           chroma_a_ptr_next,
  output logic [ADDR_BITS-1:0]           chroma_b_ptr_next,
  output logic [psaw_pkg::LINE_W-1:0]    line_count_next,
  output logic [psaw_pkg::FIELD_W-1:0]   field_ctr_next
);
  import psaw_pkg::*;

  function automatic logic [ADDR_BITS-1:0] line_delta(
    input logic [ADDR_BITS-1:0] s,
    input logic [ADDR_BITS-1:0] o,
    input logic                 test,
    input logic                 sep,
    input logic                 back
  );
    logic [ADDR_BITS-1:0] d;
    if (!sep) begin
      d = back ? (ADDR_BITS'(0) - s) : s;
    end else begin
      d = test ? o : (s - o);
      if (back) begin
        d = d - s;
      end
    end
    return d;
  endfunction

  logic                  sep;
  logic                  odd_field;
  logic [POS_W-1:0]      row;
  logic [PROD_W-1:0]     row_prod;
  logic [XB_W-1:0]       xbits;
  logic [XBYTE_W-1:0]    xbyte;
  logic [ADDR_BITS-1:0]  luma_set;

  logic [FOFS_W-1:0]     fo_c;
  logic [PITCH_W-1:0]    p_c;
  logic [POS_W-1:0]      row_c;
  logic [POS_W-1:0]      x_c;
  logic                  use_hi_bit;
  logic                  plane_a;
  logic                  plane_b;
  logic                  odd_only;
  logic                  chroma_touch;
  logic [PROD_W-1:0]     c_prod;
  logic [ADDR_BITS-1:0]  c_ofs;
  logic [ADDR_BITS-1:0]  a_set;
  logic [ADDR_BITS-1:0]  b_set;

  logic                  back;
  logic [FIELD_W-1:0]    fc;
  logic [ADDR_BITS-1:0]  luma_step;
  logic [ADDR_BITS-1:0]  c_delta;
  logic                  c_move;
  logic [ADDR_BITS-1:0]  crab_step;

  assign sep       = cfg.fields_separated;
  assign odd_field = sep & pos_y[0];
  assign row       = sep ? {1'b0, pos_y[POS_W-1:1]} : pos_y;
  assign row_prod  = PROD_W'(row) * PROD_W'(cfg.line_pitch);
  assign xbits     = XB_W'(pos_x) * XB_W'(cfg.bits_per_pixel) + XB_W'(7);
  assign xbyte     = xbits[XB_W-1:3];
  assign luma_set  = ADDR_BITS'(cfg.luma_origin)
                   + (odd_field ? ADDR_BITS'(cfg.second_field_offset) : '0)
                   + ADDR_BITS'(row_prod) + ADDR_BITS'(xbyte);

  always_comb begin
    fo_c         = cfg.second_field_offset;
    p_c          = cfg.line_pitch;
    row_c        = row;
    x_c          = pos_x;
    use_hi_bit   = 1'b0;
    plane_a      = 1'b0;
    plane_b      = 1'b0;
    odd_only     = 1'b0;
    chroma_touch = 1'b1;
    unique case (cfg.plane_layout)
      LAYOUT_3P420: begin
        fo_c       = cfg.second_field_offset >> 2;
        p_c        = cfg.line_pitch >> 1;
        row_c      = row >> 1;
        x_c        = pos_x >> 1;
        use_hi_bit = 1'b1;
        plane_a    = 1'b1;
        plane_b    = 1'b1;
        odd_only   = 1'b1;
      end
      LAYOUT_3P422: begin
        fo_c       = cfg.second_field_offset >> 1;
        p_c        = cfg.line_pitch >> 1;
        x_c        = pos_x >> 1;
        use_hi_bit = 1'b1;
        plane_a    = 1'b1;
        plane_b    = 1'b1;
      end
      LAYOUT_2P420: begin
        fo_c       = cfg.second_field_offset >> 1;
        row_c      = row >> 1;
        x_c        = {pos_x[POS_W-1:1], 1'b0};
        use_hi_bit = 1'b1;
        plane_a    = 1'b1;
        odd_only   = 1'b1;
      end
      LAYOUT_2P422: begin
        x_c     = {pos_x[POS_W-1:1], 1'b0};
        plane_a = 1'b1;
      end
      LAYOUT_3P444: begin
        plane_a = 1'b1;
        plane_b = 1'b1;
      end
      default: begin
        chroma_touch = 1'b0;
      end
    endcase
  end

  assign c_prod = PROD_W'(row_c) * PROD_W'(p_c);
  assign c_ofs  = (odd_field ? ADDR_BITS'(fo_c) : '0) + ADDR_BITS'(c_prod) + ADDR_BITS'(x_c);
  assign a_set  = chroma_touch ? (ADDR_BITS'(cfg.chroma_a_origin) + c_ofs) : chroma_a_ptr;
  assign b_set  = chroma_touch ? (ADDR_BITS'(cfg.chroma_b_origin) + c_ofs) : chroma_b_ptr;

  assign back      = (req_t'(req_type) == REQ_PREV_LINE);
  assign fc        = sep ? field_ctr + FIELD_W'(1) : field_ctr;
  assign luma_step = luma_ptr + line_delta(ADDR_BITS'(cfg.line_pitch),
                                           ADDR_BITS'(cfg.second_field_offset),
                                           fc[0], sep, back);
  assign c_delta   = line_delta(ADDR_BITS'(p_c), ADDR_BITS'(fo_c),
                                use_hi_bit ? fc[1] : fc[0], sep, back);
  assign c_move    = !odd_only || line_count[0];
  assign crab_step = ADDR_BITS'(cfg.bits_per_pixel >> 3);

  always_comb begin
    luma_ptr_next     = luma_ptr;
    chroma_a_ptr_next = chroma_a_ptr;
    chroma_b_ptr_next = chroma_b_ptr;
    line_count_next   = line_count;
    field_ctr_next    = field_ctr;
    unique case (req_t'(req_type))
      REQ_SET_POS: begin
        luma_ptr_next     = luma_set;
        chroma_a_ptr_next = a_set;
        chroma_b_ptr_next = b_set;
        line_count_next   = LINE_W'(pos_y);
        if (sep) begin
          field_ctr_next = {1'b0, pos_y[0]};
        end
      end
      REQ_NEXT_LINE, REQ_PREV_LINE: begin
        luma_ptr_next  = luma_step;
        field_ctr_next = fc;
        if (plane_a && c_move) begin
          chroma_a_ptr_next = chroma_a_ptr + c_delta;
        end
        if (plane_b && c_move) begin
          chroma_b_ptr_next = chroma_b_ptr + c_delta;
        end
        line_count_next = back ? line_count - LINE_W'(1) : line_count + LINE_W'(1);
      end
      REQ_CRAB: begin
        luma_ptr_next   = luma_ptr + crab_step;
        line_count_next = line_count + LINE_W'(1);
      end
      REQ_RCRAB: begin
        luma_ptr_next   = luma_ptr - crab_step;
        line_count_next = line_count + LINE_W'(1);
      end
      default: begin
        luma_ptr_next = luma_ptr;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/planar_surface_address_walker.sv
// Planar surface address walker: top level with request register and walker state.
// Depends on psaw_pkg, psaw_req_if, psaw_res_if, psaw_cfg_regs, psaw_next_state.
// A taken request waits in s1, then updates the walker state, which is the result beat.
// Throughput: one request per cycle if results drain; a single registered state step.
// Reset: synchronous; clears addresses, counters, valids and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "planar_surface_address_walker_macros.svh"

module planar_surface_address_walker #(
  parameter int ADDR_BITS = psaw_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [psaw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [psaw_pkg::CFG_DATA_W-1:0]  cfg_data,
  psaw_req_if.sink                         req,
  psaw_res_if.source                       res
);
  import psaw_pkg::*;

  cfg_t                  cfg;

  logic                  s1_valid;
  logic [REQ_W-1:0]      s1_req;
  logic [POS_W-1:0]      s1_x;
  logic [POS_W-1:0]      s1_y;
  logic                  res_valid;
  logic                  adv;

  logic [ADDR_BITS-1:0]  luma_ptr;
  logic [ADDR_BITS-1:0]  chroma_a_ptr;
  logic [ADDR_BITS-1:0]  chroma_b_ptr;
  logic [LINE_W-1:0]     line_count;
  logic [FIELD_W-1:0]    field_ctr;
  logic [ADDR_BITS-1:0]  luma_ptr_next;
  logic [ADDR_BITS-1:0]  chroma_a_ptr_next;
  logic [ADDR_BITS-1:0]  chroma_b_ptr_next;
  logic [LINE_W-1:0]     line_count_next;
  logic [FIELD_W-1:0]    field_ctr_next;

  psaw_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  psaw_next_state #(
    .ADDR_BITS (ADDR_BITS)
  ) u_next_state (
    .cfg               (cfg),
    .req_type          (s1_req),
    .pos_x             (s1_x),
    .pos_y             (s1_y),
    .luma_ptr          (luma_ptr),
    .chroma_a_ptr      (chroma_a_ptr),
    .chroma_b_ptr      (chroma_b_ptr),
    .line_count        (line_count),
    .field_ctr         (field_ctr),
    .luma_ptr_next     (luma_ptr_next),
    .chroma_a_ptr_next (chroma_a_ptr_next),
    .chroma_b_ptr_next (chroma_b_ptr_next),
    .line_count_next   (line_count_next),
    .field_ctr_next    (field_ctr_next)
  );

  assign adv       = s1_valid && (!res_valid || res.ready);
  assign req.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req <= req.req_type;
      s1_x   <= req.pos_x;
      s1_y   <= req.pos_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // walker state doubles as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      luma_ptr     <= '0;
      chroma_a_ptr <= '0;
      chroma_b_ptr <= '0;
      line_count   <= '0;
      field_ctr    <= '0;
    end else if (adv) begin
      luma_ptr     <= luma_ptr_next;
      chroma_a_ptr <= chroma_a_ptr_next;
      chroma_b_ptr <= chroma_b_ptr_next;
      line_count   <= line_count_next;
      field_ctr    <= field_ctr_next;
    end
  end

  assign res.valid         = res_valid;
  assign res.luma_addr     = luma_ptr;
  assign res.chroma_a_addr = chroma_a_ptr;
  assign res.chroma_b_addr = chroma_b_ptr;
  assign res.cur_line      = $signed(line_count);
  assign res.field_count   = field_ctr;

  `PSAW_ASSERT_NEXT(a_res_drop, res_valid && res.ready && !adv, !res_valid,
                    "result beat taken but valid held")
  `PSAW_ASSERT_NOW(a_in_stall, s1_valid && !adv, !req.ready,
                   "request taken while request register is blocked")
  `PSAW_ASSERT_NEXT(a_state_hold, !adv,
                    $stable(luma_ptr) && $stable(line_count) && $stable(field_ctr),
                    "walker state moved without an advance")
  `PSAW_ASSERT_NEXT(a_field_fixed, adv && !cfg.fields_separated, $stable(field_ctr),
                    "field counter moved on an interleaved surface")
  `PSAW_ASSERT_NEXT(a_crab_line, adv && (s1_req == REQ_CRAB || s1_req == REQ_RCRAB),
                    line_count == $past(line_count) + LINE_W'(1),
                    "crab step did not advance the line counter")

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Testbench for the planar surface address walker: drives requests and register writes.
// Depends on psaw_pkg, psaw_req_if, psaw_res_if and the walker RTL.
`timescale 1ns / 1ps

module tb_top;
  import psaw_pkg::*;

  localparam logic [REQ_W-1:0]    REQ_SPARE_LO    = REQ_RCRAB + 1;
  localparam logic [REQ_W-1:0]    REQ_SPARE_HI    = '1;
  localparam logic [LAYOUT_W-1:0] LAYOUT_SPARE_LO = LAYOUT_3P444 + 1;
  localparam int                  POS_MAX         = (1 << POS_W) - 1;

  typedef struct packed {
    logic [31:0]        luma;
    logic [31:0]        chroma_a;
    logic [31:0]        chroma_b;
    logic [LINE_W-1:0]  line;
    logic [FIELD_W-1:0] field;
  } walker_snap_t;

  class walker_scoreboard;
    logic [31:0]          luma_org, ca_org, cb_org;
    logic [PITCH_W-1:0]   pitch;
    logic [FOFS_W-1:0]    fofs;
    logic [BPP_W-1:0]     bpp;
    logic [LAYOUT_W-1:0]  layout;
    logic                 sep;
    logic [31:0]          luma, ca, cb;
    logic [LINE_W-1:0]    line_cnt;
    logic [FIELD_W-1:0]   field;
    walker_snap_t         pending[$];
    int                   errors;

    function new();
      luma_org = '0;
      ca_org   = '0;
      cb_org   = '0;
      pitch    = '0;
      fofs     = '0;
      bpp      = BPP_RESET;
      layout   = LAYOUT_PACKED;
      sep      = 1'b0;
      luma     = '0;
      ca       = '0;
      cb       = '0;
      line_cnt = '0;
      field    = '0;
      errors   = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] v);
      case (idx)
        REG_LUMA_ORIGIN:     luma_org = v;
        REG_CHROMA_A_ORIGIN: ca_org   = v;
        REG_CHROMA_B_ORIGIN: cb_org   = v;
        REG_LINE_PITCH:      pitch    = v[PITCH_W-1:0];
        REG_FIELD_OFFSET:    fofs     = v[FOFS_W-1:0];
        REG_BITS_PER_PIXEL:  bpp      = v[BPP_W-1:0];
        REG_PLANE_LAYOUT:    layout   = v[LAYOUT_W-1:0];
        REG_FIELDS_SEP:      sep      = v[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] line_delta(logic [31:0] s, logic [31:0] o, logic test, logic back);
      logic [31:0] d;
      if (!sep) return back ? 32'd0 - s : s;
      d = test ? o : s - o;
      if (back) d = d - s;
      return d;
    endfunction

    function void set_position(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
      logic [31:0] fo, p, l, a, b, x, y;
      fo = 32'(fofs);
      p  = 32'(pitch);
      l  = luma_org;
      x  = 32'(px);
      y  = 32'(py);
      line_cnt = LINE_W'(py);
      if (sep) begin
        field = FIELD_W'(py[0]);
        if (py[0]) l = l + fo;
        y = y >> 1;
      end
      luma = l + y * p + (x * 32'(bpp) + 32'd7) / 32'd8;
      if (layout < LAYOUT_3P420 || layout > LAYOUT_3P444) return;
      case (layout)
        LAYOUT_3P420: begin
          fo = fo >> 2;
          p  = p >> 1;
          y  = y >> 1;
          x  = x >> 1;
        end
        LAYOUT_3P422: begin
          fo = fo >> 1;
          p  = p >> 1;
          x  = x >> 1;
        end
        LAYOUT_2P420: begin
          fo   = fo >> 1;
          y    = y >> 1;
          x[0] = 1'b0;
        end
        LAYOUT_2P422: x[0] = 1'b0;
        default: ;
      endcase
      a = ca_org;
      b = cb_org;
      if (sep && field != '0) begin
        a = a + fo;
        b = b + fo;
      end
      ca = a + y * p + x;
      cb = b + y * p + x;
    endfunction

    function void line_step(logic back);
      logic        odd, da, db;
      logic [31:0] p, fo, d;
      odd = line_cnt[0];
      p   = 32'(pitch);
      fo  = 32'(fofs);
      d   = '0;
      da  = 1'b0;
      db  = 1'b0;
      if (sep) field = field + 1'b1;
      luma = luma + line_delta(p, fo, field[0], back);
      case (layout)
        LAYOUT_3P420: if (odd) begin
          d  = line_delta(p >> 1, fo >> 2, field[1], back);
          da = 1'b1;
          db = 1'b1;
        end
        LAYOUT_3P422: begin
          d  = line_delta(p >> 1, fo >> 1, field[1], back);
          da = 1'b1;
          db = 1'b1;
        end
        LAYOUT_2P420: if (odd) begin
          d  = line_delta(p, fo >> 1, field[1], back);
          da = 1'b1;
        end
        LAYOUT_2P422: begin
          d  = line_delta(p, fo, field[0], back);
          da = 1'b1;
        end
        LAYOUT_3P444: begin
          d  = line_delta(p, fo, field[0], back);
          da = 1'b1;
          db = 1'b1;
        end
        default: ;
      endcase
      if (da) ca = ca + d;
      if (db) cb = cb + d;
      line_cnt = back ? line_cnt - 1'b1 : line_cnt + 1'b1;
    endfunction

    function void note_req(logic [REQ_W-1:0] kind, logic [POS_W-1:0] px, logic [POS_W-1:0] py);
      walker_snap_t snap;
      case (kind)
        REQ_SET_POS:   set_position(px, py);
        REQ_NEXT_LINE: line_step(1'b0);
        REQ_PREV_LINE: line_step(1'b1);
        REQ_CRAB: begin
          luma     = luma + 32'(bpp >> 3);
          line_cnt = line_cnt + 1'b1;
        end
        REQ_RCRAB: begin
          luma     = luma - 32'(bpp >> 3);
          line_cnt = line_cnt + 1'b1;
        end
        default: ;
      endcase
      snap.luma     = luma;
      snap.chroma_a = ca;
      snap.chroma_b = cb;
      snap.line     = line_cnt;
      snap.field    = field;
      pending.push_back(snap);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_beat(walker_snap_t got);
      walker_snap_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result beat with no request outstanding", $time);
        return;
      end
      want = pending.pop_front();
      cmp_field("luma_addr", want.luma, got.luma);
      cmp_field("chroma_a_addr", want.chroma_a, got.chroma_a);
      cmp_field("chroma_b_addr", want.chroma_b, got.chroma_b);
      cmp_field("cur_line", 32'(want.line), 32'(got.line));
      cmp_field("field_count", 32'(want.field), 32'(got.field));
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_wen;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  psaw_req_if rq ();
  psaw_res_if #(.ADDR_BITS(32)) rs ();

  planar_surface_address_walker #(.ADDR_BITS(32)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (rq),
    .res       (rs)
  );

  walker_scoreboard sb;
  bit               src_burst;
  bit               sink_burst;
  int               sink_hold;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int stall_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return POS_W'(POS_MAX);
      default: return POS_W'($urandom);
    endcase
  endfunction

  // hold the result side off at random
  always @(negedge clk) begin
    if (rst) begin
      rs.ready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold = sink_hold - 1;
      rs.ready <= 1'b0;
    end else if (!sink_burst && $urandom_range(0, 3) == 0) begin
      sink_hold = stall_len() - 1;
      rs.ready <= 1'b0;
    end else begin
      rs.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rs.valid === 1'b1 && rs.ready === 1'b1)
      sb.check_beat({rs.luma_addr, rs.chroma_a_addr, rs.chroma_b_addr,
                     rs.cur_line, rs.field_count});
  end

  task automatic send_req(logic [REQ_W-1:0] kind, logic [POS_W-1:0] px,
                          logic [POS_W-1:0] py);
    int gap;
    gap = (src_burst || $urandom_range(0, 1) == 0) ? 0 : stall_len();
    @(negedge clk);
    if (gap != 0) begin
      rq.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rq.valid    <= 1'b1;
    rq.req_type <= kind;
    rq.pos_x    <= px;
    rq.pos_y    <= py;
    do @(posedge clk); while (rq.ready !== 1'b1);
    sb.note_req(kind, px, py);
  endtask

  task automatic drain();
    @(negedge clk) rq.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_wen   <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data  <= vals[i];
      sb.write_reg(cfg_reg_t'(i), vals[i]);
    end
    @(negedge clk) cfg_wen <= 1'b0;
  endtask

  task automatic random_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20)      send_req(REQ_SET_POS, pick_pos(), pick_pos());
    else if (r < 55) send_req(REQ_NEXT_LINE, POS_W'($urandom), POS_W'($urandom));
    else if (r < 75) send_req(REQ_PREV_LINE, POS_W'($urandom), POS_W'($urandom));
    else if (r < 85) send_req(REQ_CRAB, POS_W'($urandom), POS_W'($urandom));
    else if (r < 95) send_req(REQ_RCRAB, POS_W'($urandom), POS_W'($urandom));
    else send_req(REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)),
                  POS_W'($urandom), POS_W'($urandom));
  endtask

  initial begin
    logic [31:0] vals[8];
    sb           = new();
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_wen      = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    rq.valid     = 1'b0;
    rq.req_type  = REQ_SET_POS;
    rq.pos_x     = '0;
    rq.pos_y     = '0;
    rs.ready     = 1'b0;
    src_burst    = 1'b0;
    sink_burst   = 1'b0;
    sink_hold    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // separated fields, 4:2:0 three-plane, pitch, field offset, pixel size and chroma A origin at top value
    vals[REG_LUMA_ORIGIN]     = 32'hFFFF_FFF0;
    vals[REG_CHROMA_A_ORIGIN] = '1;
    vals[REG_CHROMA_B_ORIGIN] = '0;
    vals[REG_LINE_PITCH]      = '1;
    vals[REG_FIELD_OFFSET]    = '1;
    vals[REG_BITS_PER_PIXEL]  = '1;
    vals[REG_PLANE_LAYOUT]    = 32'(LAYOUT_3P420);
    vals[REG_FIELDS_SEP]      = 32'd1;
    program_regs(vals);
    send_req(REQ_SET_POS, '0, '0);
    send_req(REQ_SET_POS, POS_W'(POS_MAX), POS_W'(POS_MAX));
    send_req(REQ_NEXT_LINE, '0, '0);
    send_req(REQ_NEXT_LINE, '0, '0);
    send_req(REQ_PREV_LINE, '0, '0);
    send_req(REQ_NEXT_LINE, '0, '0);
    send_req(REQ_CRAB, '0, '0);
    send_req(REQ_RCRAB, '0, '0);
    send_req(REQ_SET_POS, POS_W'(POS_MAX - 1), POS_W'(2));
    send_req(REQ_PREV_LINE, '0, '0);
    send_req(REQ_SPARE_LO, POS_W'(POS_MAX), POS_W'(POS_MAX));
    send_req(REQ_SPARE_LO + 1'b1, '0, '0);
    send_req(REQ_SPARE_HI, '0, '0);
    drain();

    // progressive, unused layout code, zero pitch and zero pixel size
    vals[REG_LUMA_ORIGIN]     = '0;
    vals[REG_CHROMA_A_ORIGIN] = 32'h0000_1234;
    vals[REG_CHROMA_B_ORIGIN] = '1;
    vals[REG_LINE_PITCH]      = '0;
    vals[REG_FIELD_OFFSET]    = '0;
    vals[REG_BITS_PER_PIXEL]  = '0;
    vals[REG_PLANE_LAYOUT]    = 32'(LAYOUT_SPARE_LO);
    vals[REG_FIELDS_SEP]      = '0;
    program_regs(vals);
    send_req(REQ_SET_POS, POS_W'(POS_MAX), '0);
    send_req(REQ_SET_POS, POS_W'(1), POS_W'(POS_MAX));
    send_req(REQ_CRAB, '0, '0);
    send_req(REQ_RCRAB, '0, '0);
    send_req(REQ_NEXT_LINE, '0, '0);
    send_req(REQ_PREV_LINE, '0, '0);
    send_req(REQ_PREV_LINE, '0, '0);
    send_req(REQ_SET_POS, '0, POS_W'(1));
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      src_burst  = (ph % 4 == 1);
      sink_burst = (ph % 4 == 1) || (ph % 4 == 2);
      vals[REG_LUMA_ORIGIN]     = pick_word();
      vals[REG_CHROMA_A_ORIGIN] = pick_word();
      vals[REG_CHROMA_B_ORIGIN] = pick_word();
      vals[REG_LINE_PITCH]      = pick_word();
      vals[REG_FIELD_OFFSET]    = pick_word();
      if ($urandom_range(0, 4) == 0)
        vals[REG_BITS_PER_PIXEL] = pick_word();
      else
        vals[REG_BITS_PER_PIXEL] = ($urandom & 32'hFFFF_FFC0) | 32'($urandom_range(1, 32));
      vals[REG_PLANE_LAYOUT]    = ($urandom & ~32'h7) | 32'(ph % 8);
      vals[REG_FIELDS_SEP]      = ($urandom & ~32'h1) | 32'((ph / 8) % 2);
      program_regs(vals);
      repeat (25) random_req();
      drain();
    end

    if (sb.errors == 0) begin
      $display("PASS planar_surface_address_walker");
    end else begin
      $display("FAIL planar_surface_address_walker");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL planar_surface_address_walker");
    $finish;
  end

endmodule
